/* rtl/serial_command_line_parser_assert.svh */
// ----------------------------------------------------------------------------
// Serial command line parser assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCLP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sclp_pkg.sv */
// ----------------------------------------------------------------------------
// Serial command line parser package
// Constants, register indexes and the result record shared by the modules.
// ----------------------------------------------------------------------------
package sclp_pkg;

   localparam int MAX_LINE = 8;

   localparam logic [7:0] NEWLINE_BYTE      = 8'd10;
   localparam logic [7:0] DIGIT_ZERO        = 8'd48;
   localparam logic [7:0] TEMP_LETTER_RESET = 8'd84;
   localparam logic [7:0] FAN_LETTER_RESET  = 8'd70;

   localparam logic CSR_TEMP_LETTER = 1'b0;
   localparam logic CSR_FAN_LETTER  = 1'b1;

   localparam logic ACTION_TEMP = 1'b0;
   localparam logic ACTION_FAN  = 1'b1;

   typedef struct packed {
      logic        hit;
      logic        action;
      logic [15:0] argument;
   } result_type;

endpackage

/* rtl/sclp_channels.sv */
// ----------------------------------------------------------------------------
// Serial command line parser channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface sclp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sclp_rsp_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] argument;

   modport source (output valid, output action, output argument, input ready);
   modport sink (input valid, input action, input argument, output ready);
endinterface

/* rtl/sclp_line_engine.sv */
// ----------------------------------------------------------------------------
// Serial command line parser line engine
// Holds the current line and decides the action when a newline arrives.
// ----------------------------------------------------------------------------
module sclp_line_engine #(
   parameter int MaxLine = sclp_pkg::MAX_LINE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             temp_letter,
   input  logic [7:0]             fan_letter,
   output sclp_pkg::result_type   result
);

   localparam int LenW = $clog2(MaxLine + 1);

   logic [LenW-1:0] len_ff, len_in;
   logic [7:0]      letter_ff, letter_in;
   logic [15:0]     acc_ff, acc_in;
   logic            is_newline;
   logic            temp_match;
   logic            fan_match;

   assign is_newline = (rx_byte == sclp_pkg::NEWLINE_BYTE);
   assign temp_match = (letter_ff == temp_letter);
   assign fan_match  = (letter_ff == fan_letter);

   always_comb begin
      len_in    = len_ff;
      letter_in = letter_ff;
      acc_in    = acc_ff;
      if (step) begin
         if (!is_newline) begin
            // Characters past the line limit are dropped.
            if (len_ff < LenW'(MaxLine)) begin
               if (len_ff == '0) begin
                  letter_in = rx_byte;
                  acc_in    = '0;
               end else begin
                  acc_in = 16'(acc_ff * 16'd10 + {8'd0, rx_byte}
                               - {8'd0, sclp_pkg::DIGIT_ZERO});
               end
               len_in = len_ff + LenW'(1);
            end
         end else begin
            len_in = '0;
         end
      end
   end

   always_comb begin
      result.hit      = step && is_newline && (len_ff >= LenW'(2))
                        && (temp_match || fan_match);
      // The temperature letter wins when both letters are the same.
      result.action   = temp_match ? sclp_pkg::ACTION_TEMP : sclp_pkg::ACTION_FAN;
      result.argument = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         letter_ff <= '0;
         acc_ff    <= '0;
      end else begin
         len_ff    <= len_in;
         letter_ff <= letter_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

/* rtl/serial_command_line_parser.sv */
// ----------------------------------------------------------------------------
// Serial command line parser
// Builds command lines from received bytes; each matching line gives one action.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the req_chan channel, one byte per request.
// The first byte of a line is the command letter, later bytes fold into a
// decimal argument, and a newline closes the line. A closed line of two or
// more characters whose letter equals csr register 0 (temperature) or
// csr register 1 (fan) gives one response on rsp_chan with action and
// argument; every other line gives none.
// A newline request is taken into the input register, and its response is
// loaded into the response register when that register is free (one input
// register, one response register).
// Throughput: one request per cycle while the receiver keeps rsp_chan.ready
// high; the input register and the response register hold one item each.
// Stall: when the response register is full and not taken, the input
// register holds its byte and req_chan.ready drops once that is full too.
// Reset: synchronous; clears line state, empties both registers, sets letters
// to 'T' and 'F'. The user must write letters only while idle; it is unchecked.
// ----------------------------------------------------------------------------
`include "serial_command_line_parser_assert.svh"

module serial_command_line_parser #(
   parameter int MaxLine = sclp_pkg::MAX_LINE
) (
   input  logic               clock,
   input  logic               reset,
   sclp_req_if.sink           req_chan,
   sclp_rsp_if.source         rsp_chan,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_byte_ff, s1_byte_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_action_ff, rsp_action_in;
   logic [15:0]          rsp_argument_ff, rsp_argument_in;
   logic [7:0]           temp_letter_ff, temp_letter_in;
   logic [7:0]           fan_letter_ff, fan_letter_in;
   logic                 out_free;
   logic                 s1_advance;
   logic                 req_take;
   sclp_pkg::result_type result;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take   = req_chan.valid && req_chan.ready;

   sclp_line_engine #(
      .MaxLine (MaxLine)
   ) u_line_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (s1_advance),
      .rx_byte     (s1_byte_ff),
      .temp_letter (temp_letter_ff),
      .fan_letter  (fan_letter_ff),
      .result      (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_chan.rx_byte;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_action_in   = rsp_action_ff;
      rsp_argument_in = rsp_argument_ff;
      if (out_free) begin
         rsp_valid_in = result.hit;
         if (result.hit) begin
            rsp_action_in   = result.action;
            rsp_argument_in = result.argument;
         end
      end
   end

   always_comb begin
      temp_letter_in = temp_letter_ff;
      fan_letter_in  = fan_letter_ff;
      if (csr_write_en) begin
         case (csr_index)
            sclp_pkg::CSR_TEMP_LETTER: temp_letter_in = csr_wdata;
            sclp_pkg::CSR_FAN_LETTER:  fan_letter_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         temp_letter_ff <= sclp_pkg::TEMP_LETTER_RESET;
         fan_letter_ff  <= sclp_pkg::FAN_LETTER_RESET;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         temp_letter_ff <= temp_letter_in;
         fan_letter_ff  <= fan_letter_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff      <= s1_byte_in;
      rsp_action_ff   <= rsp_action_in;
      rsp_argument_ff <= rsp_argument_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.action   = rsp_action_ff;
   assign rsp_chan.argument = rsp_argument_ff;

   // A fresh response can only come from a newline held in the input register.
   `SCLP_ASSERT_SAME(a_rsp_from_newline,
      rsp_valid_ff && (!$past(rsp_valid_ff) || $past(rsp_chan.ready)),
      $past(s1_valid_ff) && ($past(s1_byte_ff) == sclp_pkg::NEWLINE_BYTE),
      "response loaded without a newline in the input register")

   // A blocked input register keeps its byte.
   `SCLP_ASSERT_NEXT(a_s1_hold,
      s1_valid_ff && !out_free,
      s1_valid_ff && $stable(s1_byte_ff),
      "input register changed while the response side was stalled")

   // Requests are refused only when both registers are full and stalled.
   `SCLP_ASSERT_SAME(a_ready_low,
      !req_chan.ready,
      s1_valid_ff && rsp_valid_ff && !rsp_chan.ready,
      "request refused while a register had room")

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Serial command line parser testbench
// Sends command lines byte by byte and predicts the action and argument of
// every closed line. Checks each response against the oldest prediction, and
// changes the command letters between phases while the parser is idle.
// ----------------------------------------------------------------------------
module tb;
   import sclp_pkg::*;

   localparam int DIRECTED_ROWS   = 25;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      logic [7:0]  rx_byte;
      bit          fixed_exp;
      logic        action;
      logic [15:0] argument;
   } directed_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic csr_index;
   logic [7:0] csr_wdata;

   sclp_req_if req_chan ();
   sclp_rsp_if rsp_chan ();

   serial_command_line_parser dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Parser state as the testbench sees it.
   logic [7:0]  temp_key = TEMP_LETTER_RESET;
   logic [7:0]  fan_key = FAN_LETTER_RESET;
   logic [3:0]  line_count = '0;
   logic [7:0]  line_letter = '0;
   logic [15:0] line_value = '0;

   result_type pending_actions[$];
   int mismatch_count = 0;
   int quiet_cycles = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_off_pending = 1'b0;

   directed_row directed_rows [DIRECTED_ROWS] = '{
      '{NEWLINE_BYTE, 1'b0, ACTION_TEMP, 16'd0},
      '{TEMP_LETTER_RESET, 1'b0, ACTION_TEMP, 16'd0},
      '{NEWLINE_BYTE, 1'b0, ACTION_TEMP, 16'd0},
      '{TEMP_LETTER_RESET, 1'b0, ACTION_TEMP, 16'd0},
      '{"7", 1'b0, ACTION_TEMP, 16'd0},
      '{NEWLINE_BYTE, 1'b1, ACTION_TEMP, 16'd7},
      '{FAN_LETTER_RESET, 1'b0, ACTION_TEMP, 16'd0},
      '{"9", 1'b0, ACTION_TEMP, 16'd0},
      '{NEWLINE_BYTE, 1'b1, ACTION_FAN, 16'd9},
      '{8'd0, 1'b0, ACTION_TEMP, 16'd0},
      '{"5", 1'b0, ACTION_TEMP, 16'd0},
      '{NEWLINE_BYTE, 1'b0, ACTION_TEMP, 16'd0},
      '{FAN_LETTER_RESET, 1'b0, ACTION_TEMP, 16'd0},
      '{8'd255, 1'b0, ACTION_TEMP, 16'd0},
      '{NEWLINE_BYTE, 1'b0, ACTION_TEMP, 16'd0},
      '{TEMP_LETTER_RESET, 1'b0, ACTION_TEMP, 16'd0},
      '{"1", 1'b0, ACTION_TEMP, 16'd0},
      '{"2", 1'b0, ACTION_TEMP, 16'd0},
      '{"3", 1'b0, ACTION_TEMP, 16'd0},
      '{"4", 1'b0, ACTION_TEMP, 16'd0},
      '{"5", 1'b0, ACTION_TEMP, 16'd0},
      '{"6", 1'b0, ACTION_TEMP, 16'd0},
      '{"7", 1'b0, ACTION_TEMP, 16'd0},
      '{"8", 1'b0, ACTION_TEMP, 16'd0},
      '{NEWLINE_BYTE, 1'b0, ACTION_TEMP, 16'd0}
   };

   always #4 clock = ~clock;

   // Folds one received byte into the line state and returns the action that
   // a closing newline produces, if any.
   function automatic result_type parse_byte(input logic [7:0] rx);
      result_type act;
      act = '0;
      if (rx != NEWLINE_BYTE) begin
         // Once the line is full, further characters are dropped.
         if (line_count < MAX_LINE) begin
            if (line_count == 4'd0) begin
               line_letter = rx;
               line_value = '0;
            end else begin
               line_value = line_value * 16'd10 + {8'd0, rx} - {8'd0, DIGIT_ZERO};
            end
            line_count = line_count + 4'd1;
         end
      end else begin
         if (line_count >= 4'd2) begin
            // The temperature letter takes priority when both letters match.
            if (line_letter == temp_key) begin
               act.hit = 1'b1;
               act.action = ACTION_TEMP;
               act.argument = line_value;
            end else if (line_letter == fan_key) begin
               act.hit = 1'b1;
               act.action = ACTION_FAN;
               act.argument = line_value;
            end
         end
         line_count = '0;
      end
      return act;
   endfunction

   // Entered and left at a falling edge.
   task automatic push_byte(input logic [7:0] rx, input bit fixed_exp = 1'b0,
                            input logic fixed_action = ACTION_TEMP,
                            input logic [15:0] fixed_arg = '0);
      int gap;
      result_type act;
      gap = 0;
      if (req_idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.rx_byte = rx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      act = parse_byte(rx);
      if (fixed_exp) begin
         act.hit = 1'b1;
         act.action = fixed_action;
         act.argument = fixed_arg;
      end
      if (act.hit) pending_actions.push_back(act);
      @(negedge clock);
   endtask

   task automatic random_traffic(input int item_goal);
      int sent;
      int pick;
      int digits;
      int k;
      logic [7:0] rx;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            push_byte(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) rx = temp_key;
            else if (pick < 85) rx = fan_key;
            else rx = 8'($urandom_range(0, 255));
            push_byte(rx);
            pick = $urandom_range(0, 99);
            if (pick < 10) digits = 0;
            else if (pick < 85) digits = $urandom_range(1, 5);
            else digits = $urandom_range(6, 12);
            for (k = 0; k < digits; k++) begin
               if ($urandom_range(0, 9) == 0) rx = 8'($urandom_range(0, 255));
               else rx = DIGIT_ZERO + 8'($urandom_range(0, 9));
               push_byte(rx);
            end
            push_byte(NEWLINE_BYTE);
            // Characters past a full line are dropped but still sent as requests.
            sent += digits + 2;
         end
      end
   endtask

   task automatic settle();
      req_chan.valid = 1'b0;
      while (pending_actions.size() != 0) @(negedge clock);
      // Lines that produce nothing may still be in flight.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_letters(input logic [7:0] temp_value, input logic [7:0] fan_value);
      csr_write_en = 1'b1;
      csr_index = CSR_TEMP_LETTER;
      csr_wdata = temp_value;
      @(negedge clock);
      csr_index = CSR_FAN_LETTER;
      csr_wdata = fan_value;
      @(negedge clock);
      csr_write_en = 1'b0;
      temp_key = temp_value;
      fan_key = fan_value;
   endtask

   // Response side: random back-pressure plus one long hold-off on request.
   initial begin
      int ready_gap;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         ready_gap = 0;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            ready_gap = HOLD_OFF_CYCLES;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(1, 14);
         end
         if (ready_gap > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (ready_gap - 1) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_actions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: action %0d argument %0d",
                        rsp_chan.action, rsp_chan.argument);
         end else begin
            want = pending_actions.pop_front();
            if (rsp_chan.action !== want.action || rsp_chan.argument !== want.argument) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"response mismatch: expected action %0d argument %0d, ",
                            "got action %0d argument %0d"},
                           want.action, want.argument, rsp_chan.action, rsp_chan.argument);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending_actions.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      logic [7:0] shared_letter;
      logic [7:0] other_letter;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_TEMP_LETTER;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         push_byte(directed_rows[i].rx_byte, directed_rows[i].fixed_exp,
                   directed_rows[i].action, directed_rows[i].argument);
      random_traffic(200);

      // Extreme letters, with the response side stalled long enough to back
      // up the request channel.
      settle();
      write_letters(8'd0, 8'd255);
      hold_off_pending = 1'b1;
      random_traffic(200);

      settle();
      write_letters(8'd255, 8'd0);
      random_traffic(200);

      // Both letters equal: every matching line must become a temperature action.
      settle();
      shared_letter = 8'($urandom_range(0, 255));
      if (shared_letter == NEWLINE_BYTE) shared_letter = TEMP_LETTER_RESET;
      write_letters(shared_letter, shared_letter);
      random_traffic(200);

      settle();
      shared_letter = 8'($urandom_range(0, 255));
      other_letter = 8'($urandom_range(0, 255));
      write_letters(shared_letter, other_letter);
      random_traffic(200);

      settle();
      write_letters(TEMP_LETTER_RESET, FAN_LETTER_RESET);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      random_traffic(300);

      settle();
      if (mismatch_count == 0 && pending_actions.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
